[hdl/tcw_pkg.sv]
// Shared types and constants for the text console character writer.
// Used by the front end, the item queue, the back end and the top level.
`timescale 1ns / 1ps

package tcw_pkg;

    // Stream payload widths (tdata in whole bytes)
    localparam int TDATA_IN_W  = 24;
    localparam int TUSER_IN_W  = 2;
    localparam int TDATA_OUT_W = 40;

    // Field widths
    localparam int CMD_W      = 2;
    localparam int CHAR_W     = 8;
    localparam int ATTR_W     = 8;
    localparam int INDEX_W    = 11;
    localparam int COL_OUT_W  = 7;
    localparam int ROW_OUT_W  = 5;
    localparam int OFS_OUT_W  = 11;
    localparam int CELL_W     = 16;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef logic [COL_OUT_W-1:0] t_col_out;
    typedef logic [ROW_OUT_W-1:0] t_row_out;
    typedef logic [OFS_OUT_W-1:0] t_ofs_out;

    // Commands
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_HI  = 8'h7F;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

    // What the back end has to do with one item
    typedef enum logic [2:0] {
        K_NOP   = 3'd0,
        K_PRINT = 3'd1,
        K_BS    = 3'd2,
        K_TAB   = 3'd3,
        K_CR    = 3'd4,
        K_LF    = 3'd5,
        K_CLEAR = 3'd6,
        K_READ  = 3'd7
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [CHAR_W-1:0]   char_code;
        logic [INDEX_W-1:0]  read_index;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef struct packed {
        logic q_full;
        logic back_ready;
    } t_front_status;

    typedef struct packed {
        t_col_out           cursor_column;
        t_row_out           cursor_row;
        t_ofs_out           cursor_offset;
        logic [CELL_W-1:0]  cell_data;
        logic               scrolled;
    } t_result;

endpackage

[hdl/text_console_char_writer.sv]
// Top level of the text console character writer.
// Depends on tcw_pkg, tcw_front, tcw_queue and tcw_back.
`timescale 1ns / 1ps

// Text-mode console engine with a COLUMNS x ROWS store of 16-bit cells.
// Input stream (s_axis): one item per command; tuser carries the command
// (put character, clear screen, read one cell), tdata the character byte
// and the linear read index. Output stream (m_axis): one result per item
// with the cursor column, row and linear offset, the cell read and a
// scroll flag. Configuration channel (i_cfg_*): sets the attribute byte
// used for stored characters and blanks; write it only while idle.
// Work per item, from the queue to the result register:
//   cursor-only moves, ignored bytes, unused commands: no store access
//   printable character: one write; read of one cell: one read
//   clear screen: all cells blanked, one cell written per cycle
//   any item that scrolls: row move plus blank row,
//   one cell per cycle through the single-port-pair store
// A four-entry queue lets the input side run ahead of the back end.
// After reset the store is blanked with attribute 0x0F, one cell per
// cycle; s_axis_tready stays low until then.
// When the receiver stalls, the result waits in its output register, the
// back end holds at the next result and the queue fills before the input
// side stalls.
module text_console_char_writer #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata, low to high: char_code[7:0], read_index[18:8], zero [23:19]
    input  logic [tcw_pkg::TDATA_IN_W-1:0]     s_axis_tdata,
    // tuser: cmd[1:0]
    input  logic [tcw_pkg::TUSER_IN_W-1:0]     s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata, low to high: cursor_column[6:0], cursor_row[11:7],
    // cursor_offset[22:12], cell_data[38:23], scrolled[39]
    output logic [tcw_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tcw_pkg::ATTR_W-1:0]         i_cfg_data
);
    import tcw_pkg::*;

    logic [ATTR_W-1:0]  r_char_attribute;
    t_front_status      front_status;
    t_queue_status      queue_status;
    t_item              push_item;
    t_item              head_item;
    logic               push;
    logic               pop;
    logic               back_ready;
    t_result            result;

    // Attribute register; writes are always taken
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_attribute <= RESET_ATTR;
        end else if (i_cfg_valid) begin
            r_char_attribute <= i_cfg_data;
        end
    end

    assign front_status.q_full     = queue_status.full;
    assign front_status.back_ready = back_ready;

    tcw_front u_front (
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_cmd        (s_axis_tuser[CMD_W-1:0]),
        .i_char_code  (s_axis_tdata[CHAR_W-1:0]),
        .i_read_index (s_axis_tdata[CHAR_W+INDEX_W-1:CHAR_W]),
        .i_status     (front_status),
        .o_push       (push),
        .o_item       (push_item)
    );

    tcw_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .i_pop    (pop),
        .o_item   (head_item),
        .o_status (queue_status)
    );

    tcw_back #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_attr      (r_char_attribute),
        .i_q_valid   (!queue_status.empty),
        .i_q_item    (head_item),
        .o_q_pop     (pop),
        .o_ready     (back_ready),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (result)
    );

    // Pack result fields, first field lowest
    assign m_axis_tdata = {result.scrolled, result.cell_data, result.cursor_offset,
                           result.cursor_row, result.cursor_column};

endmodule

[hdl/tcw_front.sv]
// Front end: accepts stream items and classifies them into back-end kinds.
// Depends on tcw_pkg; feeds tcw_queue.
`timescale 1ns / 1ps

module tcw_front (
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [tcw_pkg::CMD_W-1:0]    i_cmd,
    input  logic [tcw_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [tcw_pkg::INDEX_W-1:0]  i_read_index,
    input  tcw_pkg::t_front_status       i_status,
    output logic                         o_push,
    output tcw_pkg::t_item               o_item
);
    import tcw_pkg::*;

    t_kind kind;

    // Take an item while the queue has room and the screen store is ready
    assign o_ready = !i_status.q_full && i_status.back_ready;
    assign o_push  = i_valid && o_ready;

    // Classify command and character byte
    always_comb begin
        kind = K_NOP;
        case (i_cmd)
            CMD_PUT: begin
                case (i_char_code)
                    CH_BACKSPACE: kind = K_BS;
                    CH_TAB:       kind = K_TAB;
                    CH_CR:        kind = K_CR;
                    CH_LF:        kind = K_LF;
                    default: begin
                        if (i_char_code >= CH_BLANK && i_char_code <= CH_PRINT_HI) begin
                            kind = K_PRINT;
                        end
                    end
                endcase
            end
            CMD_CLEAR: kind = K_CLEAR;
            CMD_READ:  kind = K_READ;
            default:   kind = K_NOP;
        endcase
    end

    assign o_item.kind       = kind;
    assign o_item.char_code  = i_char_code;
    assign o_item.read_index = i_read_index;

endmodule

[hdl/tcw_queue.sv]
// Short item queue between the front end and the back end.
// Depends on tcw_pkg for the item type and the depth.
`timescale 1ns / 1ps

module tcw_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  tcw_pkg::t_item           i_item,
    input  logic                     i_pop,
    output tcw_pkg::t_item           o_item,
    output tcw_pkg::t_queue_status   o_status
);
    import tcw_pkg::*;

    t_item              r_slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               do_push;
    logic               do_pop;

    assign o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_item  = r_slots[r_rd_ptr];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Hold item payloads
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_item;
        end
    end

endmodule

[hdl/tcw_back.sv]
// Back end: cursor, screen store, reset/clear/scroll sweeps and the result register.
// Depends on tcw_pkg; takes items from tcw_queue.
`timescale 1ns / 1ps

module tcw_back #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [tcw_pkg::ATTR_W-1:0]  i_attr,
    input  logic                        i_q_valid,
    input  tcw_pkg::t_item              i_q_item,
    output logic                        o_q_pop,
    output logic                        o_ready,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output tcw_pkg::t_result            o_res
);
    import tcw_pkg::*;

    localparam int CELLS       = COLUMNS * ROWS;
    localparam int ADDR_W      = $clog2(CELLS);
    localparam int COL_W       = $clog2(COLUMNS);
    localparam int CX_W        = $clog2(COLUMNS + TAB_STOP);
    localparam int ROW_W       = $clog2(ROWS);
    localparam int TAB_W       = $clog2(TAB_STOP);
    localparam int SCROLL_LAST = CELLS - COLUMNS - 1;

    typedef enum logic [5:0] {
        S_INIT   = 6'b000001,
        S_IDLE   = 6'b000010,
        S_FILL   = 6'b000100,
        S_SCROLL = 6'b001000,
        S_READ   = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [ADDR_W-1:0]   r_addr;
    logic [COL_W-1:0]    r_col;
    logic [TAB_W-1:0]    r_phase;
    logic [ROW_W-1:0]    r_line;
    logic [ADDR_W-1:0]   r_row_base;
    logic [CELL_W-1:0]   r_cell;
    logic                r_scrolled;
    logic [CELL_W-1:0]   r_rd_data;
    logic [CELL_W-1:0]   r_mem [CELLS];
    t_result             r_res;
    logic                r_res_valid;

    logic [COL_W-1:0]    n_col;
    logic [TAB_W-1:0]    n_phase;
    logic [ROW_W-1:0]    n_line;
    logic [ADDR_W-1:0]   n_row_base;
    logic                do_scroll;
    logic                read_in_range;
    logic                take;
    logic                res_free;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [CELL_W-1:0]   mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;

    assign take          = (r_state == S_IDLE) && i_q_valid;
    assign o_q_pop       = take;
    assign o_ready       = (r_state != S_INIT);
    assign res_free      = !r_res_valid || i_res_ready;
    assign read_in_range = (32'(i_q_item.read_index) < 32'(CELLS));
    assign o_res_valid   = r_res_valid;
    assign o_res         = r_res;

    // Cursor step for one put-character item
    always_comb begin
        logic [CX_W-1:0] col_x;
        logic            line_inc;
        col_x    = CX_W'(r_col);
        n_phase  = r_phase;
        line_inc = 1'b0;
        case (i_q_item.kind)
            K_BS: begin
                if (r_col != '0) begin
                    col_x   = col_x - 1'b1;
                    n_phase = (r_phase == '0) ? TAB_W'(TAB_STOP - 1) : r_phase - 1'b1;
                end
            end
            K_TAB: begin
                col_x   = col_x + CX_W'(TAB_STOP) - CX_W'(r_phase);
                n_phase = '0;
            end
            K_CR: begin
                col_x   = '0;
                n_phase = '0;
            end
            K_LF: begin
                col_x    = '0;
                n_phase  = '0;
                line_inc = 1'b1;
            end
            K_PRINT: begin
                col_x   = col_x + 1'b1;
                n_phase = (r_phase == TAB_W'(TAB_STOP - 1)) ? '0 : r_phase + 1'b1;
            end
            default: ;
        endcase
        // Wrap past the last column
        if (col_x >= CX_W'(COLUMNS)) begin
            col_x    = '0;
            n_phase  = '0;
            line_inc = 1'b1;
        end
        n_col      = COL_W'(col_x);
        n_line     = r_line;
        n_row_base = r_row_base;
        do_scroll  = 1'b0;
        // Scroll when moving down from the last row
        if (line_inc) begin
            if (r_line == ROW_W'(ROWS - 1)) begin
                do_scroll = 1'b1;
            end else begin
                n_line     = r_line + 1'b1;
                n_row_base = r_row_base + ADDR_W'(COLUMNS);
            end
        end
    end

    // Drive the store ports
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = {i_attr, CH_BLANK};
        mem_re    = 1'b0;
        mem_raddr = r_addr + ADDR_W'(COLUMNS + 1);
        case (r_state)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_wdata = {RESET_ATTR, CH_BLANK};
            end
            S_IDLE: begin
                if (take) begin
                    if (i_q_item.kind == K_PRINT) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_row_base + ADDR_W'(r_col);
                        mem_wdata = {i_attr, i_q_item.char_code};
                    end
                    if (do_scroll) begin
                        mem_re    = 1'b1;
                        mem_raddr = ADDR_W'(COLUMNS);
                    end else if (i_q_item.kind == K_READ && read_in_range) begin
                        mem_re    = 1'b1;
                        mem_raddr = ADDR_W'(i_q_item.read_index);
                    end
                end
            end
            S_FILL: begin
                mem_we = 1'b1;
            end
            S_SCROLL: begin
                mem_we    = 1'b1;
                mem_wdata = r_rd_data;
                mem_re    = (r_addr != ADDR_W'(SCROLL_LAST));
            end
            default: ;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (r_addr == ADDR_W'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (take) begin
                    if (i_q_item.kind == K_CLEAR) begin
                        n_state = S_FILL;
                    end else if (do_scroll) begin
                        n_state = S_SCROLL;
                    end else if (i_q_item.kind == K_READ && read_in_range) begin
                        n_state = S_READ;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_FILL: begin
                if (r_addr == ADDR_W'(CELLS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_SCROLL: begin
                if (r_addr == ADDR_W'(SCROLL_LAST)) begin
                    n_state = S_FILL;
                end
            end
            S_READ: n_state = S_DONE;
            S_DONE: begin
                if (res_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    // Control state: sequencer, sweep address, cursor, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_addr      <= '0;
            r_col       <= '0;
            r_phase     <= '0;
            r_line      <= '0;
            r_row_base  <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_INIT, S_FILL, S_SCROLL: begin
                    if (r_addr == ADDR_W'(SCROLL_LAST) && r_state == S_SCROLL) begin
                        r_addr <= ADDR_W'(CELLS - COLUMNS);
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_IDLE: begin
                    r_addr <= '0;
                    if (take) begin
                        if (i_q_item.kind == K_CLEAR) begin
                            r_col      <= '0;
                            r_phase    <= '0;
                            r_line     <= '0;
                            r_row_base <= '0;
                        end else begin
                            r_col      <= n_col;
                            r_phase    <= n_phase;
                            r_line     <= n_line;
                            r_row_base <= n_row_base;
                        end
                    end
                end
                default: ;
            endcase
            // Hold result until taken
            if (r_state == S_DONE && res_free) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // Payload: cell read, scroll flag and result
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cell     <= '0;
            r_scrolled <= do_scroll;
        end
        if (r_state == S_READ) begin
            r_cell <= r_rd_data;
        end
        if (r_state == S_DONE && res_free) begin
            r_res.cursor_column <= t_col_out'(r_col);
            r_res.cursor_row    <= t_row_out'(r_line);
            r_res.cursor_offset <= t_ofs_out'(r_row_base + ADDR_W'(r_col));
            r_res.cell_data     <= r_cell;
            r_res.scrolled      <= r_scrolled;
        end
    end

    // Screen store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

endmodule

[hdl/tcw_checker.sv]
// Port-level checks for text_console_char_writer, attached by bind.
// Depends only on the top level's ports and parameters.
`timescale 1ns / 1ps

module tcw_checker #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);
    logic [6:0]  col;
    logic [4:0]  row;
    logic [10:0] ofs;
    logic        scr;

    assign col = m_axis_tdata[6:0];
    assign row = m_axis_tdata[11:7];
    assign ofs = m_axis_tdata[22:12];
    assign scr = m_axis_tdata[39];

    // Store is blanked after reset before any item is taken
    a_reset_blocks_input: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input taken right after reset");

    // Stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Cursor column stays on screen
    a_column_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (32'(col) < COLUMNS))
        else $error("cursor column past last column");

    // A scroll leaves the cursor on the last row
    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && scr |-> (row == 5'(ROWS - 1)))
        else $error("scroll without cursor on last row");

    // Linear offset matches row and column
    a_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((ROWS > 32) || (ofs == 11'(32'(row) * COLUMNS + 32'(col)))))
        else $error("cursor offset does not match row and column");

endmodule

bind text_console_char_writer tcw_checker #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS)
) u_tcw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[sim/text_console_char_writer_tb.sv]
// Self-checking testbench for text_console_char_writer: drives commands on the
// input stream, predicts each result, and checks every result item field by field.
// Depends on tcw_pkg and the text_console_char_writer RTL.
`timescale 1ns / 1ps

module text_console_char_writer_tb;
    import tcw_pkg::*;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int TAB_STOP    = 8;
    localparam int CELLS       = COLUMNS * ROWS;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_TAIL  = 20;
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    typedef struct {
        t_col_out           column;
        t_row_out           row;
        t_ofs_out           offset;
        logic [CELL_W-1:0]  cell_value;
        logic               scrolled;
    } t_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data = '0;

    // Console shadow: screen store, cursor and attribute
    logic [CELL_W-1:0] screen [0:CELLS-1];
    int                cur_col;
    int                cur_row;
    logic [ATTR_W-1:0] attr;

    t_report expected_results[$];
    int      mismatches = 0;
    int      quiet_cycles = 0;
    bit      no_gaps = 1'b0;

    text_console_char_writer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .TAB_STOP(TAB_STOP)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Apply one accepted command to the shadow console and queue its result
    task automatic console_apply(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] code,
                                 input logic [INDEX_W-1:0] idx);
        t_report r;
        int      ofs;
        r.cell_value = '0;
        r.scrolled = 1'b0;
        case (cmd)
            CMD_PUT: begin
                if (code == CH_BACKSPACE) begin
                    if (cur_col > 0) cur_col--;
                end else if (code == CH_TAB) begin
                    cur_col = cur_col + TAB_STOP - (cur_col % TAB_STOP);
                end else if (code == CH_CR) begin
                    cur_col = 0;
                end else if (code == CH_LF) begin
                    cur_col = 0;
                    cur_row++;
                end else if (code >= CH_BLANK && code <= CH_PRINT_HI) begin
                    screen[cur_row * COLUMNS + cur_col] = {attr, code};
                    cur_col++;
                end
                // Wrap past the last column, scroll past the last row
                if (cur_col >= COLUMNS) begin
                    cur_col = 0;
                    cur_row++;
                end
                if (cur_row >= ROWS) begin
                    for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
                    for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = {attr, CH_BLANK};
                    cur_row = ROWS - 1;
                    r.scrolled = 1'b1;
                end
            end
            CMD_CLEAR: begin
                for (int i = 0; i < CELLS; i++) screen[i] = {attr, CH_BLANK};
                cur_col = 0;
                cur_row = 0;
            end
            CMD_READ: begin
                if (idx < CELLS) r.cell_value = screen[idx];
            end
            default: begin
            end
        endcase
        ofs = cur_row * COLUMNS + cur_col;
        r.column = t_col_out'(cur_col);
        r.row = t_row_out'(cur_row);
        r.offset = t_ofs_out'(ofs);
        expected_results.push_back(r);
    endtask

    // Send one item, with random idle cycles ahead of it unless gaps are off
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] code,
                             input logic [INDEX_W-1:0] idx);
        @(negedge i_clk);
        while (!no_gaps && $urandom_range(0, 99) < 11) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {5'b0, idx, code};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        console_apply(cmd, code, idx);
    endtask

    task automatic put_char(input logic [CHAR_W-1:0] code);
        send_item(CMD_PUT, code, INDEX_W'($urandom_range(0, 2047)));
    endtask

    task automatic read_cell(input int idx);
        send_item(CMD_READ, CHAR_W'($urandom_range(0, 255)), INDEX_W'(idx));
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Write the attribute register; only called while the block is idle
    task automatic write_attr(input logic [ATTR_W-1:0] value);
        drain_results();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        attr = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [CHAR_W-1:0] printable_code();
        return CHAR_W'($urandom_range(32, 127));
    endfunction

    // Bytes outside the printable range, control codes included
    function automatic logic [CHAR_W-1:0] stray_code();
        if ($urandom_range(0, 1) == 0) return CHAR_W'($urandom_range(0, 31));
        return CHAR_W'($urandom_range(128, 255));
    endfunction

    // Reset contents, backspace at column zero, the spare command
    task automatic test_reset_state();
        read_cell(0);
        read_cell(CELLS - 1);
        put_char(CH_BACKSPACE);
        send_item(CMD_SPARE, 8'hFF, 11'h7FF);
    endtask

    // Every character class at least once, then reads including out-of-range ones
    task automatic test_put_codes();
        put_char(8'h41);
        put_char(CH_BLANK);
        put_char(CH_PRINT_HI);
        put_char(CH_BACKSPACE);
        put_char(CH_TAB);
        put_char(8'h00);
        put_char(8'h1F);
        put_char(8'h80);
        put_char(8'hFF);
        put_char(CH_CR);
        put_char(CH_LF);
        read_cell(0);
        read_cell(1);
        read_cell(2);
        read_cell(CELLS);
        read_cell(2047);
    endtask

    // Clear with both attribute extremes
    task automatic test_clear();
        write_attr(8'hFF);
        send_item(CMD_CLEAR, 8'h00, 11'h000);
        read_cell(0);
        read_cell(CELLS - 1);
        write_attr(8'h00);
        put_char(8'h5A);
        send_item(CMD_CLEAR, 8'hFF, 11'h7FF);
        read_cell(0);
    endtask

    // Walk to the bottom row, then scroll by wrap, by line feed and by tab
    task automatic test_scroll();
        write_attr(8'h3C);
        for (int i = 0; i < ROWS - 1; i++) put_char(CH_LF);
        for (int i = 0; i < 9; i++) put_char(CH_TAB);
        for (int i = 0; i < 8; i++) put_char(printable_code());
        read_cell((ROWS - 2) * COLUMNS + COLUMNS - 1);
        read_cell((ROWS - 1) * COLUMNS);
        put_char(printable_code());
        put_char(CH_LF);
        for (int i = 0; i < COLUMNS / TAB_STOP; i++) put_char(CH_TAB);
        read_cell((ROWS - 3) * COLUMNS);
        read_cell(CELLS - 1);
    endtask

    // Random text lines with reads, stray commands and a rare clear
    task automatic test_random_text(input int count, input logic [ATTR_W-1:0] attr_value,
                                    input bit gapless);
        int sent;
        int pick;
        int len;
        int near;
        write_attr(attr_value);
        no_gaps = gapless;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 170) : $urandom_range(0, 40);
                for (int i = 0; i < len; i++) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 85) put_char(printable_code());
                    else if (pick < 90) put_char(CH_TAB);
                    else if (pick < 95) put_char(CH_BACKSPACE);
                    else put_char(stray_code());
                end
                sent += len;
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    put_char(CH_CR);
                    put_char(CH_LF);
                    sent += 2;
                end else if (pick < 85) begin
                    put_char(CH_LF);
                    sent++;
                end
            end else if (pick < 87) begin
                // Reads around the cursor hit freshly written cells
                if ($urandom_range(0, 1) == 0) begin
                    near = cur_row * COLUMNS + cur_col - $urandom_range(0, 2 * COLUMNS);
                    read_cell(near < 0 ? 0 : near);
                end else begin
                    read_cell($urandom_range(0, 2047));
                end
                sent++;
            end else if (pick < 99) begin
                pick = $urandom_range(0, 2);
                send_item(pick == 0 ? CMD_PUT : (pick == 1 ? CMD_READ : CMD_SPARE),
                          CHAR_W'($urandom_range(0, 255)), INDEX_W'($urandom_range(0, 2047)));
                sent++;
            end else begin
                send_item(CMD_CLEAR, CHAR_W'($urandom_range(0, 255)),
                          INDEX_W'($urandom_range(0, 2047)));
                sent++;
            end
        end
        no_gaps = 1'b0;
    endtask

    // Receiver stalls at random except during the gapless stretch
    always @(negedge i_clk) begin
        m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= 11);
    end

    // Compare each result item with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_report want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $error("result item with no expectation: tdata %h", m_axis_tdata);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tdata[6:0] !== want.column) begin
                    $error("cursor_column: expected %0d, got %0d", want.column,
                           m_axis_tdata[6:0]);
                    mismatches++;
                end
                if (m_axis_tdata[11:7] !== want.row) begin
                    $error("cursor_row: expected %0d, got %0d", want.row, m_axis_tdata[11:7]);
                    mismatches++;
                end
                if (m_axis_tdata[22:12] !== want.offset) begin
                    $error("cursor_offset: expected %0d, got %0d", want.offset,
                           m_axis_tdata[22:12]);
                    mismatches++;
                end
                if (m_axis_tdata[38:23] !== want.cell_value) begin
                    $error("cell_data: expected %h, got %h", want.cell_value,
                           m_axis_tdata[38:23]);
                    mismatches++;
                end
                if (m_axis_tdata[39] !== want.scrolled) begin
                    $error("scrolled: expected %0d, got %0d", want.scrolled, m_axis_tdata[39]);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run if no channel moves an item for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("text_console_char_writer_tb: FAIL");
            $finish;
        end
    end

    initial begin
        attr = RESET_ATTR;
        cur_col = 0;
        cur_row = 0;
        for (int i = 0; i < CELLS; i++) screen[i] = {RESET_ATTR, CH_BLANK};
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_put_codes();
        test_clear();
        test_scroll();
        test_random_text(300, 8'h00, 1'b0);
        test_random_text(300, 8'($urandom_range(1, 254)), 1'b1);
        test_random_text(300, 8'hFF, 1'b0);
        test_random_text(300, 8'($urandom_range(0, 255)), 1'b0);

        drain_results();
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("text_console_char_writer_tb: PASS");
        end else begin
            $display("text_console_char_writer_tb: FAIL");
        end
        $finish;
    end

endmodule
